### design/lts_pkg.sv
// Package for the link timeout status supervisor.
// Holds the item and result types, the mode and LED codes, and the blink test.
// Depends on nothing.
package lts_pkg;

	localparam int BLINK_PERIOD = 10;
	localparam int HANDSHAKE_TICKS = 9;
	localparam int BlinkDiv = (BLINK_PERIOD == 0) ? 1 : BLINK_PERIOD;

	localparam logic [7:0] TIMEOUT_RESET = 8'd100;
	localparam logic [7:0] SILENCE_LIMIT = 8'd250;

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_HANDSHAKE = 3'd1,
		MODE_NODATA = 3'd2,
		MODE_DATA = 3'd3,
		MODE_ATTN = 3'd4
	} lts_mode_t;

	localparam logic [1:0] LED_NONE = 2'd0;
	localparam logic [1:0] LED_OFFLINE = 2'd1;
	localparam logic [1:0] LED_READY = 2'd2;
	localparam logic [1:0] LED_DISCON = 2'd3;

	localparam logic [1:0] ALERT_ON_SET = 2'd1;
	localparam logic [1:0] ALERT_ON_CLEAR = 2'd2;

	typedef struct packed {
		logic data_seen;
		logic [7:0] rx_byte;
		logic [1:0] buttons_n;
	} lts_item_t;

	typedef struct packed {
		logic link_ready;
		logic [1:0] led_code;
		logic [2:0] link_mode;
	} lts_result_t;

	// True when the count is a whole multiple of the blink period.
	function automatic logic blink_hit(input logic [7:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= 255; k++) begin
			if (k * BlinkDiv == int'(v)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

### design/lts_step.sv
// Supervisor state and the per-tick transition and action logic.
// Depends on lts_pkg.
module lts_step (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input lts_pkg::lts_item_t item,
	input logic [7:0] timeout_ticks,
	output lts_pkg::lts_result_t result
);

	lts_pkg::lts_mode_t mode_q, mode_d;
	logic [7:0] silence_q, silence_d;
	logic [3:0] hs_count_q, hs_count_d;
	logic [1:0] alert_mask_q, alert_mask_d;
	logic ready_q, ready_d;
	logic [1:0] led_q, led_d;
	logic [1:0] pressed;
	logic alert_bit;
	logic alert_hit;

	function automatic logic [7:0] silence_next(input logic [7:0] cnt, input logic [7:0] tmo);
		logic [8:0] sum;
		sum = {1'b0, tmo} + 9'd1;
		if (cnt > lts_pkg::SILENCE_LIMIT) begin
			return sum[8] ? 8'hFF : sum[7:0];
		end
		return cnt + 8'd1;
	endfunction

	assign pressed = ~item.buttons_n;
	assign alert_bit = item.rx_byte[7];
	assign alert_hit = (alert_mask_q == lts_pkg::ALERT_ON_SET && alert_bit)
		|| (alert_mask_q == lts_pkg::ALERT_ON_CLEAR && !alert_bit);

	always_comb begin
		mode_d = mode_q;
		silence_d = silence_q;
		hs_count_d = hs_count_q;
		alert_mask_d = alert_mask_q;
		ready_d = ready_q;
		led_d = led_q;
		unique case (mode_q)
			lts_pkg::MODE_START: begin
				hs_count_d = 4'd0;
				mode_d = lts_pkg::MODE_HANDSHAKE;
			end
			lts_pkg::MODE_HANDSHAKE: begin
				silence_d = 8'd0;
				ready_d = 1'b0;
				led_d = lts_pkg::LED_OFFLINE;
				if (hs_count_q >= 4'(lts_pkg::HANDSHAKE_TICKS)) begin
					mode_d = lts_pkg::MODE_NODATA;
				end else if (item.data_seen) begin
					hs_count_d = hs_count_q + 4'd1;
				end
			end
			lts_pkg::MODE_NODATA: begin
				priority if (alert_hit) begin
					ready_d = 1'b1;
					mode_d = lts_pkg::MODE_ATTN;
				end else if (pressed != 2'd0) begin
					ready_d = 1'b0;
					mode_d = lts_pkg::MODE_ATTN;
				end else if (item.data_seen) begin
					ready_d = 1'b1;
					led_d = lts_pkg::LED_READY;
					mode_d = lts_pkg::MODE_DATA;
				end else begin
					silence_d = silence_next(silence_q, timeout_ticks);
				end
			end
			lts_pkg::MODE_DATA: begin
				if (!item.data_seen) begin
					silence_d = 8'd0;
					mode_d = lts_pkg::MODE_NODATA;
				end
			end
			lts_pkg::MODE_ATTN: begin
				mode_d = lts_pkg::MODE_NODATA;
			end
			default: begin
				mode_d = lts_pkg::MODE_START;
			end
		endcase

		if (mode_d == lts_pkg::MODE_NODATA) begin
			if (silence_d > timeout_ticks) begin
				ready_d = 1'b0;
				if (alert_mask_d == 2'd0) begin
					led_d = lts_pkg::LED_DISCON;
				end
			end
		end else if (mode_d == lts_pkg::MODE_ATTN) begin
			alert_mask_d = pressed;
			silence_d = silence_next(silence_d, timeout_ticks);
			if (lts_pkg::blink_hit(silence_d)) begin
				led_d = led_d[0] ? lts_pkg::LED_READY : lts_pkg::LED_OFFLINE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lts_pkg::MODE_START;
			silence_q <= 8'd0;
			hs_count_q <= 4'd0;
			alert_mask_q <= 2'd0;
			ready_q <= 1'b0;
			led_q <= lts_pkg::LED_NONE;
		end else if (advance) begin
			mode_q <= mode_d;
			silence_q <= silence_d;
			hs_count_q <= hs_count_d;
			alert_mask_q <= alert_mask_d;
			ready_q <= ready_d;
			led_q <= led_d;
		end
	end

	assign result.link_ready = ready_d;
	assign result.led_code = led_d;
	assign result.link_mode = mode_d;

endmodule

### design/lts_out_reg.sv
// Result register that holds one finished result until the consumer takes it.
// Depends on lts_pkg.
module lts_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input lts_pkg::lts_result_t d,
	output logic can_load,
	output logic result_valid,
	input logic result_stall,
	output lts_pkg::lts_result_t result
);

	logic valid_s2;
	lts_pkg::lts_result_t data_s2;

	assign can_load = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= d;
		end
	end

	assign result_valid = valid_s2;
	assign result = data_s2;

endmodule

### design/link_timeout_status_fsm_unit.sv
// Top level of the link timeout status supervisor.
// Depends on lts_pkg, lts_step and lts_out_reg.
//
// Channel   Handshake                  Payload
// item      item_valid / item_stall    item (lts_item_t)
// result    result_valid / result_stall result (lts_result_t)
// cfg       cfg_valid / cfg_ready      cfg_data (timeout_ticks)
//
// One item is taken per cycle while the result side is not stalled; its result
// passes through the input register and then the result register, and is taken
// from the result register when result_stall is low.
// The supervisor state advances when the input register hands its item on.
// A stalled result holds the result register, which then stalls the input side.
// Reset clears the state to start mode and loads the timeout with 100.
module link_timeout_status_fsm_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input lts_pkg::lts_item_t item,
	output logic result_valid,
	input logic result_stall,
	output lts_pkg::lts_result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);

	logic valid_s1;
	lts_pkg::lts_item_t item_s1;
	logic [7:0] timeout_q;
	logic can_load;
	logic advance;
	logic accept;
	lts_pkg::lts_result_t step_result;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= lts_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	lts_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.timeout_ticks(timeout_q),
		.result(step_result)
	);

	lts_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.d(step_result),
		.can_load(can_load),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

### test/lts_supervisor_checker.sv
// Checker for the link timeout status supervisor: watches the item, result and cfg
// channels, predicts each result from its own copy of the supervisor state and
// compares it field by field. Depends on lts_pkg.
`timescale 1ns / 1ps

module lts_supervisor_checker
	import lts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input lts_item_t item,
	input logic result_valid,
	input logic result_stall,
	input lts_result_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [7:0] cfg_data,
	output int pending,
	output int failures
);

	lts_mode_t mode;
	logic [7:0] timeout_ticks;
	logic [7:0] silence_count;
	logic [3:0] handshake_count;
	logic [1:0] alert_mask;
	logic ready_flag;
	logic [1:0] led_state;
	lts_result_t expected_results[$];
	int mismatch_count = 0;

	function automatic logic [7:0] next_silence(input logic [7:0] cnt);
		if (cnt > SILENCE_LIMIT) begin
			return (timeout_ticks == 8'hFF) ? 8'hFF : timeout_ticks + 8'd1;
		end
		return cnt + 8'd1;
	endfunction

	function automatic lts_result_t advance_supervisor(input lts_item_t it);
		logic [1:0] pressed;
		logic alert_hit;
		lts_result_t r;
		pressed = ~it.buttons_n;
		alert_hit = (alert_mask == ALERT_ON_SET && it.rx_byte[7]) ||
			(alert_mask == ALERT_ON_CLEAR && !it.rx_byte[7]);
		case (mode)
			MODE_START: begin
				handshake_count = '0;
				mode = MODE_HANDSHAKE;
			end
			MODE_HANDSHAKE: begin
				silence_count = '0;
				ready_flag = 1'b0;
				led_state = LED_OFFLINE;
				if (handshake_count >= HANDSHAKE_TICKS) begin
					mode = MODE_NODATA;
				end else if (it.data_seen) begin
					handshake_count = handshake_count + 4'd1;
				end
			end
			MODE_NODATA: begin
				if (alert_hit) begin
					ready_flag = 1'b1;
					mode = MODE_ATTN;
				end else if (pressed != '0) begin
					ready_flag = 1'b0;
					mode = MODE_ATTN;
				end else if (it.data_seen) begin
					ready_flag = 1'b1;
					led_state = LED_READY;
					mode = MODE_DATA;
				end else begin
					silence_count = next_silence(silence_count);
				end
			end
			MODE_DATA: begin
				if (!it.data_seen) begin
					silence_count = '0;
					mode = MODE_NODATA;
				end
			end
			MODE_ATTN: begin
				mode = MODE_NODATA;
			end
			default: begin
				mode = MODE_START;
			end
		endcase
		if (mode == MODE_NODATA) begin
			if (silence_count > timeout_ticks) begin
				ready_flag = 1'b0;
				if (alert_mask == '0) begin
					led_state = LED_DISCON;
				end
			end
		end else if (mode == MODE_ATTN) begin
			alert_mask = pressed;
			silence_count = next_silence(silence_count);
			if (int'(silence_count) % BlinkDiv == 0) begin
				led_state = ((led_state & LED_OFFLINE) != '0) ? LED_READY : LED_OFFLINE;
			end
		end
		r.link_ready = ready_flag;
		r.led_code = led_state;
		r.link_mode = mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lts_result_t want;
		if (!arst_n) begin
			mode = MODE_START;
			timeout_ticks = TIMEOUT_RESET;
			silence_count = '0;
			handshake_count = '0;
			alert_mask = '0;
			ready_flag = 1'b0;
			led_state = LED_NONE;
			expected_results.delete();
			pending <= 0;
			failures <= mismatch_count;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_ticks = cfg_data;
			end
			if (item_valid && !item_stall) begin
				expected_results.push_back(advance_supervisor(item));
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no expected result pending");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.link_ready !== want.link_ready) begin
						$error("link_ready: expected %0d, actual %0d",
							want.link_ready, result.link_ready);
						mismatch_count++;
					end
					if (result.led_code !== want.led_code) begin
						$error("led_code: expected %0d, actual %0d",
							want.led_code, result.led_code);
						mismatch_count++;
					end
					if (result.link_mode !== want.link_mode) begin
						$error("link_mode: expected %0d, actual %0d",
							want.link_mode, result.link_mode);
						mismatch_count++;
					end
				end
			end
			pending <= expected_results.size();
			failures <= mismatch_count;
		end
	end

endmodule

### test/tb_link_timeout_status_fsm_unit.sv
// Testbench top for the link timeout status supervisor: drives ticks and timeout
// writes with random idling on both sides and gives the verdict.
// Depends on lts_pkg, link_timeout_status_fsm_unit and lts_supervisor_checker.
`timescale 1ns / 1ps

module tb_link_timeout_status_fsm_unit;
	import lts_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	lts_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	lts_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;
	int pending;
	int failures;
	int send_idle = 0;
	int recv_idle = 0;

	link_timeout_status_fsm_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	lts_supervisor_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pending(pending),
		.failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	function automatic lts_item_t make_tick(input logic seen, input logic alert,
			input logic [1:0] btn_n);
		lts_item_t it;
		it.data_seen = seen;
		it.rx_byte = {alert, 7'($urandom)};
		it.buttons_n = btn_n;
		return it;
	endfunction

	task automatic send_tick(input lts_item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic settle_pipeline();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] ticks);
		cfg_data <= ticks;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] ticks, input int budget, input bit long_quiet);
		int sent;
		int kind;
		int len;
		bit paused;
		logic alert;
		settle_pipeline();
		write_timeout(ticks);
		sent = 0;
		paused = 1'b0;
		while (sent < budget) begin
			kind = $urandom_range(99);
			if (long_quiet) begin
				kind = 0;
			end
			if (kind < 35) begin
				if (long_quiet || $urandom_range(59) == 0) begin
					len = $urandom_range(280, 255);
				end else begin
					len = $urandom_range(20, 1);
				end
				long_quiet = 1'b0;
				alert = 1'($urandom_range(1));
				repeat (len) send_tick(make_tick(1'b0, alert, 2'b11));
				sent += len;
			end else if (kind < 60) begin
				len = $urandom_range(8, 1);
				repeat (len) send_tick(make_tick(1'b1, 1'($urandom_range(1)), 2'b11));
				send_tick(make_tick(1'b0, 1'($urandom_range(1)), 2'b11));
				sent += len + 1;
			end else if (kind < 80) begin
				len = $urandom_range(2, 1);
				repeat (len) begin
					send_tick(make_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
						2'($urandom_range(2))));
				end
				sent += len;
			end else begin
				len = $urandom_range(5, 1);
				repeat (len) send_tick(lts_item_t'(11'($urandom)));
				sent += len;
			end
			if (!paused && sent >= budget / 2) begin
				settle_pipeline();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_timeout(8'd0);

		send_tick(lts_item_t'({1'b0, 8'hFF, 2'b00}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'hFF, 2'b00}));
		send_tick(lts_item_t'({1'b1, 8'h00, 2'b01}));
		send_tick(lts_item_t'({1'b1, 8'h80, 2'b10}));
		send_tick(lts_item_t'({1'b1, 8'h7F, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h55, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'hAA, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'h55, 2'b00}));
		send_tick(lts_item_t'({1'b1, 8'hFF, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'h80, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h7F, 2'b10}));
		send_tick(lts_item_t'({1'b0, 8'h80, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h80, 2'b01}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b00}));
		send_tick(lts_item_t'({1'b1, 8'hFF, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'hFF, 2'b11}));
		send_tick(lts_item_t'({1'b1, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h80, 2'b11}));
		send_tick(lts_item_t'({1'b0, 8'h00, 2'b01}));

		send_idle = 32;
		recv_idle = 81;
		run_phase(8'd255, 260, 1'b1);
		run_phase(8'd250, 260, 1'b1);
		send_idle = 81;
		recv_idle = 32;
		run_phase(8'($urandom_range(249, 2)), 260, 1'b0);
		run_phase(8'd1, 260, 1'b0);
		send_idle = 0;
		recv_idle = 0;
		run_phase(TIMEOUT_RESET, 260, 1'b0);
		run_phase(8'd0, 260, 1'b0);

		settle_pipeline();
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
